// File: design/kpsce_pkg.sv
// Shared constants, types and helpers for the keypad scan and code entry block.
package kpsce_pkg;

  localparam int ROWS     = 4;
  localparam int COLS     = 3;
  localparam int CODE_LEN = 4;

  localparam int MATRIX_W = 12;
  localparam int KEY_W    = 4;
  localparam int GAP_W    = 8;
  localparam int DIGITS_W = 16;
  localparam int SLOTS    = DIGITS_W / KEY_W;
  localparam int CNT_W    = 3;
  localparam int POS_W    = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1;
  localparam int COL_W    = (COLS > 1) ? $clog2(COLS) : 1;

  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [KEY_W-1:0] EMPTY_SLOT = 4'hF;
  localparam logic [KEY_W-1:0] NO_KEY     = 4'hF;
  localparam logic [GAP_W-1:0] GAP_MAX    = 8'hFF;

  localparam logic [GAP_W-1:0] RESET_REPEAT_GAP = 8'd50;
  localparam logic [KEY_W-1:0] RESET_CLEAR_KEY  = 4'd11;
  localparam logic [KEY_W-1:0] RESET_ENTER_KEY  = 4'd9;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REPEAT_GAP = 2'd0,
    CFG_CLEAR_KEY  = 2'd1,
    CFG_ENTER_KEY  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [GAP_W-1:0] repeat_gap;
    logic [KEY_W-1:0] clear_key;
    logic [KEY_W-1:0] enter_key;
  } cfg_t;

  // First and second rows that carry a pressed column, as key indices.
  typedef struct packed {
    logic             any0;
    logic [KEY_W-1:0] key0;
    logic             any1;
    logic [KEY_W-1:0] key1;
  } scan_t;

  function automatic logic [COL_W-1:0] top_col(input logic [COLS-1:0] bits);
    logic [COL_W-1:0] pos;
    pos = '0;
    for (int k = 0; k < COLS; k++) begin
      if (bits[k]) begin
        pos = COL_W'(k);
      end
    end
    return pos;
  endfunction

endpackage

// File: design/kpsce_front.sv
// Front end: classify one poll into its first and second pressed rows.
module kpsce_front (
  input  logic [kpsce_pkg::MATRIX_W-1:0] key_matrix,
  output kpsce_pkg::scan_t               scan
);

  always_comb begin
    logic [kpsce_pkg::COLS-1:0]  bits;
    logic [kpsce_pkg::KEY_W-1:0] key;
    scan = '0;
    for (int r = 0; r < kpsce_pkg::ROWS; r++) begin
      bits = key_matrix[r*kpsce_pkg::COLS +: kpsce_pkg::COLS];
      key  = kpsce_pkg::KEY_W'(r * kpsce_pkg::COLS)
           + kpsce_pkg::KEY_W'(kpsce_pkg::top_col(bits));
      if (bits != '0) begin
        if (!scan.any0) begin
          scan.any0 = 1'b1;
          scan.key0 = key;
        end else if (!scan.any1) begin
          scan.any1 = 1'b1;
          scan.key1 = key;
        end
      end
    end
  end

endmodule

// File: design/kpsce_queue.sv
// Two-entry queue of classified polls between the front and back ends.
module kpsce_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  kpsce_pkg::scan_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output kpsce_pkg::scan_t head_data
);

  kpsce_pkg::scan_t                  mem_r [kpsce_pkg::QDEPTH];
  logic [kpsce_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [kpsce_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [kpsce_pkg::QCNT_W-1:0]      count_r, count_nxt;

  assign full       = (count_r == kpsce_pkg::QCNT_W'(kpsce_pkg::QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == kpsce_pkg::QPTR_W'(kpsce_pkg::QDEPTH - 1)) ? '0
                 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == kpsce_pkg::QPTR_W'(kpsce_pkg::QDEPTH - 1)) ? '0
                 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: design/kpsce_back.sv
// Back end: repeat suppression, code store and the registered result word.
module kpsce_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  kpsce_pkg::cfg_t                     cfg,
  input  logic                                head_valid,
  input  kpsce_pkg::scan_t                    head_data,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_key_valid,
  output logic [kpsce_pkg::KEY_W-1:0]         out_key_index,
  output logic                                out_code_changed,
  output logic [kpsce_pkg::CNT_W-1:0]         out_entered_count,
  output logic [kpsce_pkg::DIGITS_W-1:0]      out_code_digits
);

  logic [kpsce_pkg::KEY_W-1:0] last_key_r, last_key_nxt;
  logic [kpsce_pkg::GAP_W-1:0] idle_r, idle_nxt;
  logic [kpsce_pkg::KEY_W-1:0] store_r [kpsce_pkg::CODE_LEN];
  logic [kpsce_pkg::KEY_W-1:0] store_nxt [kpsce_pkg::CODE_LEN];
  logic [kpsce_pkg::CNT_W-1:0] pos_r, pos_nxt;
  logic                        out_valid_r;
  logic                        key_valid_r, key_valid_nxt;
  logic [kpsce_pkg::KEY_W-1:0] key_index_r, key_index_nxt;
  logic                        changed_r, changed_nxt;
  logic [kpsce_pkg::DIGITS_W-1:0] digits_r, digits_nxt;

  assign pop               = head_valid && (!out_valid_r || out_ready);
  assign out_valid         = out_valid_r;
  assign out_key_valid     = key_valid_r;
  assign out_key_index     = key_index_r;
  assign out_code_changed  = changed_r;
  assign out_entered_count = pos_r;
  assign out_code_digits   = digits_r;

  always_comb begin
    logic                        first_new;
    logic                        reported;
    logic [kpsce_pkg::KEY_W-1:0] key;
    first_new = head_data.any0
             && ((head_data.key0 != last_key_r) || (idle_r > cfg.repeat_gap));
    reported  = first_new || head_data.any1;
    key       = first_new ? head_data.key0 : head_data.key1;

    last_key_nxt = last_key_r;
    idle_nxt     = idle_r;
    pos_nxt      = pos_r;
    changed_nxt  = 1'b0;
    for (int i = 0; i < kpsce_pkg::CODE_LEN; i++) begin
      store_nxt[i] = store_r[i];
    end

    if (reported) begin
      last_key_nxt = key;
      idle_nxt     = '0;
      if (key == cfg.clear_key) begin
        for (int i = 0; i < kpsce_pkg::CODE_LEN; i++) begin
          store_nxt[i] = kpsce_pkg::EMPTY_SLOT;
        end
        pos_nxt     = '0;
        changed_nxt = 1'b1;
      end else if (pos_r < kpsce_pkg::CNT_W'(kpsce_pkg::CODE_LEN)
                   && key != cfg.enter_key) begin
        store_nxt[pos_r[kpsce_pkg::POS_W-1:0]] = key;
        pos_nxt     = pos_r + 1'b1;
        changed_nxt = 1'b1;
      end
    end else if (head_data.any0) begin
      // held key: count cleared, then one idle poll counted
      idle_nxt = kpsce_pkg::GAP_W'(1);
    end else if (idle_r <= cfg.repeat_gap && idle_r != kpsce_pkg::GAP_MAX) begin
      idle_nxt = idle_r + 1'b1;
    end

    key_valid_nxt = reported;
    key_index_nxt = reported ? key : '0;

    digits_nxt = '0;
    for (int i = 0; i < kpsce_pkg::SLOTS; i++) begin
      if (i < kpsce_pkg::CODE_LEN) begin
        digits_nxt[i*kpsce_pkg::KEY_W +: kpsce_pkg::KEY_W] = store_nxt[i];
      end else begin
        digits_nxt[i*kpsce_pkg::KEY_W +: kpsce_pkg::KEY_W] = kpsce_pkg::EMPTY_SLOT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      last_key_r  <= kpsce_pkg::NO_KEY;
      idle_r      <= '0;
      pos_r       <= '0;
      for (int i = 0; i < kpsce_pkg::CODE_LEN; i++) begin
        store_r[i] <= kpsce_pkg::EMPTY_SLOT;
      end
    end else begin
      if (pop) begin
        out_valid_r <= 1'b1;
        last_key_r  <= last_key_nxt;
        idle_r      <= idle_nxt;
        pos_r       <= pos_nxt;
        for (int i = 0; i < kpsce_pkg::CODE_LEN; i++) begin
          store_r[i] <= store_nxt[i];
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      key_valid_r <= key_valid_nxt;
      key_index_r <= key_index_nxt;
      changed_r   <= changed_nxt;
      digits_r    <= digits_nxt;
    end
  end

endmodule

// File: design/keypad_scan_code_entry.sv
// Top level: keypad poll scanner with repeat suppression and code entry store.
// An accepted poll is stored in the queue, then registered in the back end's out_* word.
// Throughput: one poll per cycle while out_ready stays high; a full queue drops in_ready.
// A two-entry queue between front and back absorbs a stalled output for two words.
// Reset (rst_n low, synchronous): queue and output emptied, last key none, idle count 0,
// code store all empty, configuration back to gap 50, clear key 11, enter key 9.
module keypad_scan_code_entry (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // poll input
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [kpsce_pkg::MATRIX_W-1:0]       in_key_matrix,
  // result output
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_key_valid,
  output logic [kpsce_pkg::KEY_W-1:0]          out_key_index,
  output logic                                 out_code_changed,
  output logic [kpsce_pkg::CNT_W-1:0]          out_entered_count,
  output logic [kpsce_pkg::DIGITS_W-1:0]       out_code_digits,
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [kpsce_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [kpsce_pkg::CFG_DATA_W-1:0]     cfg_data
);

  kpsce_pkg::cfg_t  cfg_r, cfg_nxt;
  kpsce_pkg::scan_t front_scan;
  kpsce_pkg::scan_t head_data;
  logic             q_full;
  logic             head_valid;
  logic             q_pop;
  logic             in_fire;

  // Configuration is always accepted; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        kpsce_pkg::CFG_REPEAT_GAP: cfg_nxt.repeat_gap = cfg_data;
        kpsce_pkg::CFG_CLEAR_KEY:  cfg_nxt.clear_key  = cfg_data[kpsce_pkg::KEY_W-1:0];
        kpsce_pkg::CFG_ENTER_KEY:  cfg_nxt.enter_key  = cfg_data[kpsce_pkg::KEY_W-1:0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.repeat_gap <= kpsce_pkg::RESET_REPEAT_GAP;
      cfg_r.clear_key  <= kpsce_pkg::RESET_CLEAR_KEY;
      cfg_r.enter_key  <= kpsce_pkg::RESET_ENTER_KEY;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: take a poll whenever the queue has room and classify its rows.
  assign in_ready = !q_full;
  assign in_fire  = in_valid && in_ready;

  kpsce_front u_front (
    .key_matrix (in_key_matrix),
    .scan       (front_scan)
  );

  // Queue: hold classified words while the back end is stalled.
  kpsce_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_fire),
    .push_data  (front_scan),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  // Back: decide the report, update the code store, register the result word.
  kpsce_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .head_valid        (head_valid),
    .head_data         (head_data),
    .pop               (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_key_valid     (out_key_valid),
    .out_key_index     (out_key_index),
    .out_code_changed  (out_code_changed),
    .out_entered_count (out_entered_count),
    .out_code_digits   (out_code_digits)
  );

  // A full queue only happens behind a stalled result word.
  a_full_needs_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("queue full without a pending result");

  a_idle_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_key_valid |-> out_key_index == '0)
    else $error("key index set without a reported key");

  a_change_needs_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_code_changed |-> out_key_valid)
    else $error("code store changed without a reported key");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entered_count <= kpsce_pkg::CNT_W'(kpsce_pkg::CODE_LEN))
    else $error("entered count beyond code length");

endmodule
